// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the tandem repeat counter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition at one edge implies a consequence at the next edge
`define ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/ltrc_pkg.sv =====
// Types, constants and helper functions of the tandem repeat counter
package ltrc_pkg;

    localparam int MAX_PATTERN   = 8;
    localparam int RUN_BITS      = 20;
    localparam int CHAR_BITS     = 8;
    localparam int PATTERN_BITS  = 64;
    localparam int LEN_REG_BITS  = 4;
    localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
    localparam int IDX_BITS      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int GAP_BITS      = 4;
    localparam int OUT_DATA_BITS = ((RUN_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [GAP_BITS-1:0] GAP_TOP = {GAP_BITS{1'b1}};
    localparam logic [RUN_BITS-1:0] RUN_TOP = {RUN_BITS{1'b1}};

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_CHARS  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 1'd1;

    localparam logic [LEN_REG_BITS-1:0] PATTERN_LENGTH_RESET = 4'd1;

    typedef logic [CHAR_BITS-1:0] char_t;
    typedef logic [LEN_BITS-1:0]  len_t;
    typedef logic [RUN_BITS-1:0]  run_t;

    // One accepted character as seen by the run tracker
    typedef struct packed {
        logic accept;
        logic last;
        logic window_hit;
    } step_t;

    // Tracker state exposed for checking
    typedef struct packed {
        len_t chars_seen;
        logic matched_before;
        run_t current_run;
        run_t best_run;
    } trk_status_t;

    // Clamp the programmed length into 1..MAX_PATTERN
    function automatic len_t used_length(input logic [LEN_REG_BITS-1:0] raw);
        len_t n;
        if (raw == '0) begin
            n = len_t'(1);
        end else if (raw > LEN_REG_BITS'(MAX_PATTERN)) begin
            n = len_t'(MAX_PATTERN);
        end else begin
            n = len_t'(raw);
        end
        return n;
    endfunction

    // Pattern byte that a window slot holding the k-th newest character must equal
    function automatic char_t pattern_byte(input logic [PATTERN_BITS-1:0] pat,
                                           input len_t len,
                                           input logic [IDX_BITS-1:0] slot);
        logic [IDX_BITS-1:0] idx;
        idx = IDX_BITS'(len - len_t'(1) - len_t'(slot));
        return pat[idx*CHAR_BITS +: CHAR_BITS];
    endfunction

endpackage

// ===== rtl/longest_tandem_repeat_counter.sv =====
// Top level of the longest tandem repeat counter
//
// The text enters on the s_ channel, one character per transfer, with s_tlast
// on its final character. The pattern (up to eight bytes, first character in
// the lowest byte) and its length are written on the cfg_ port while no text
// is in flight; a write takes effect for the next character.
// A row of eight window cells shifts the text along; each cell compares the
// character moving into it against its pattern byte, and a tracker turns the
// combined hit into non-overlapping matches and runs of adjacent matches.
// Throughput: one character per cycle while no result waits untaken in the output
// register. The longest run of a text appears on m_tdata in the cycle after the
// transfer of its final character, and only then.
// When the receiver stalls, the result waits in the output register and the
// input accepts characters again as soon as that result is taken.
// Reset clears the run state and the output valid flag and sets the pattern to
// zero with length one; no clearing pass is needed.
module longest_tandem_repeat_counter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [ltrc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [ltrc_pkg::PATTERN_BITS-1:0]      cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [ltrc_pkg::CHAR_BITS-1:0]         s_tdata,  // [7:0] text_char
    input  logic                                   s_tlast,  // end_of_text
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [ltrc_pkg::OUT_DATA_BITS-1:0]     m_tdata   // [19:0] longest_run, rest zero
);

`include "assert_macros.svh"

    logic [ltrc_pkg::PATTERN_BITS-1:0] pattern_reg;
    logic [ltrc_pkg::LEN_REG_BITS-1:0] length_reg;
    ltrc_pkg::len_t                    len;
    ltrc_pkg::char_t                   cell_char [ltrc_pkg::MAX_PATTERN];
    ltrc_pkg::char_t                   cell_in   [ltrc_pkg::MAX_PATTERN];
    logic [ltrc_pkg::MAX_PATTERN-1:0]  cell_hit;
    ltrc_pkg::step_t                   step;
    ltrc_pkg::run_t                    result;
    ltrc_pkg::trk_status_t             trk_stat;
    logic                              accept;
    logic                              m_valid_reg, m_valid_next;
    ltrc_pkg::run_t                    m_data_reg, m_data_next;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= ltrc_pkg::PATTERN_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ltrc_pkg::REG_PATTERN_CHARS:  pattern_reg <= cfg_wdata;
                ltrc_pkg::REG_PATTERN_LENGTH: length_reg  <= cfg_wdata[ltrc_pkg::LEN_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign len = ltrc_pkg::used_length(length_reg);

    // Accept while the output register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Row of window cells, newest character in cell zero
    for (genvar k = 0; k < ltrc_pkg::MAX_PATTERN; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_in[k] = s_tdata;
        end else begin : g_link
            assign cell_in[k] = cell_char[k-1];
        end

        ltrc_cell u_cell (
            .aclk     (aclk),
            .shift    (accept),
            .char_in  (cell_in[k]),
            .want     (ltrc_pkg::pattern_byte(pattern_reg, len,
                                              ltrc_pkg::IDX_BITS'(k))),
            .used     (ltrc_pkg::len_t'(k) < len),
            .char_out (cell_char[k]),
            .hit      (cell_hit[k])
        );
    end

    assign step.accept     = accept;
    assign step.last       = s_tlast;
    assign step.window_hit = &cell_hit;

    ltrc_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .len     (len),
        .result  (result),
        .status  (trk_stat)
    );

    // Output register: load on the final character, drop once transferred
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept && s_tlast) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ltrc_pkg::OUT_DATA_BITS'(m_data_reg);

    // Checks on the run tracking and the result path
    `ASSERT_NEXT(a_last_gives_result, accept && s_tlast, m_valid_reg, "final character gave no result")
    `ASSERT_NEXT(a_last_clears_state, accept && s_tlast, trk_stat.chars_seen == '0, "text state not cleared after final character")
    `ASSERT_ALWAYS(a_best_covers_run, trk_stat.best_run >= trk_stat.current_run, "best run below current run")
    `ASSERT_ALWAYS(a_no_run_without_match, trk_stat.matched_before || (trk_stat.current_run == '0), "run counted without a match")

endmodule

// ===== rtl/ltrc_cell.sv =====
// One window cell: holds a text character and compares the incoming one
module ltrc_cell (
    input  logic             aclk,
    input  logic             shift,
    input  ltrc_pkg::char_t  char_in,
    input  ltrc_pkg::char_t  want,
    input  logic             used,
    output ltrc_pkg::char_t  char_out,
    output logic             hit
);

    ltrc_pkg::char_t char_reg;
    ltrc_pkg::char_t char_next;

    // Take the character on char_in on every transfer
    always_comb begin
        char_next = shift ? char_in : char_reg;
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
    end

    // Compare the character that moves in; slots beyond the pattern always agree
    assign hit      = !used || (char_in == want);
    assign char_out = char_reg;

endmodule

// ===== rtl/ltrc_tracker.sv =====
// Match spacing and run tracking for the tandem repeat counter
module ltrc_tracker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ltrc_pkg::step_t       step,
    input  ltrc_pkg::len_t        len,
    output ltrc_pkg::run_t        result,
    output ltrc_pkg::trk_status_t status
);

    ltrc_pkg::len_t                     seen_reg, seen_next, seen_inc;
    logic [ltrc_pkg::GAP_BITS-1:0]      gap_reg, gap_next, gap_inc;
    logic                               matched_reg, matched_next;
    ltrc_pkg::run_t                     cur_reg, cur_next, cur_cand;
    ltrc_pkg::run_t                     best_reg, best_next, best_cand;
    logic                               take;
    logic                               extend;

    always_comb begin
        // Advance the saturating counters for the new character
        seen_inc = (seen_reg < ltrc_pkg::len_t'(ltrc_pkg::MAX_PATTERN)) ?
                   seen_reg + ltrc_pkg::len_t'(1) : seen_reg;
        gap_inc  = (gap_reg < ltrc_pkg::GAP_TOP) ?
                   gap_reg + ltrc_pkg::GAP_BITS'(1) : gap_reg;

        // Count a match only if it does not overlap the previous one
        take   = (seen_inc >= len) && step.window_hit &&
                 (!matched_reg || (gap_inc >= ltrc_pkg::GAP_BITS'(len)));
        extend = matched_reg && (gap_inc == ltrc_pkg::GAP_BITS'(len));

        if (extend) begin
            cur_cand = (cur_reg == ltrc_pkg::RUN_TOP) ? cur_reg
                                                      : cur_reg + ltrc_pkg::run_t'(1);
        end else begin
            cur_cand = ltrc_pkg::run_t'(1);
        end
        best_cand = (cur_cand > best_reg) ? cur_cand : best_reg;

        seen_next    = seen_reg;
        gap_next     = gap_reg;
        matched_next = matched_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        result       = best_reg;

        if (step.accept) begin
            seen_next = seen_inc;
            gap_next  = gap_inc;
            if (take) begin
                matched_next = 1'b1;
                gap_next     = '0;
                cur_next     = cur_cand;
                best_next    = best_cand;
            end
            result = best_next;
            // Drop all text state once the final character is in
            if (step.last) begin
                seen_next    = '0;
                gap_next     = '0;
                matched_next = 1'b0;
                cur_next     = '0;
                best_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            gap_reg     <= '0;
            matched_reg <= 1'b0;
            cur_reg     <= '0;
            best_reg    <= '0;
        end else begin
            seen_reg    <= seen_next;
            gap_reg     <= gap_next;
            matched_reg <= matched_next;
            cur_reg     <= cur_next;
            best_reg    <= best_next;
        end
    end

    assign status.chars_seen     = seen_reg;
    assign status.matched_before = matched_reg;
    assign status.current_run    = cur_reg;
    assign status.best_run       = best_reg;

endmodule
